// File: sv/eucl_pkg.sv
// ----------------------------------------------------------------------------
// eucl_pkg
// Shared widths, constants and the command and status types that pass
// between the controller and the datapath of the L2 distance engine.
// ----------------------------------------------------------------------------
package eucl_pkg;

    localparam int ELEM_W = 16;
    localparam int DIFF_W = ELEM_W + 1;
    localparam int MAG_W  = ELEM_W;
    localparam int SQ_W   = 2 * MAG_W;
    localparam int SUM_W  = 48;
    localparam int DIST_W = SUM_W / 2;

    // Highest trial bit of the bitwise square root: the top even bit position.
    localparam logic [SUM_W-1:0] ROOT_BIT_INIT = SUM_W'(1) << (SUM_W - 2);

    typedef struct packed {
        logic idle;
        logic capture;
        logic square;
        logic accumulate;
        logic root_step;
        logic out_load;
    } eucl_cmd_t;

    typedef struct packed {
        logic last_pending;
        logic root_done;
        logic out_blocked;
    } eucl_status_t;

endpackage

// File: sv/eucl_ctrl.sv
// ----------------------------------------------------------------------------
// eucl_ctrl
// Controller state machine: sequences capture, squaring, accumulation,
// the square root iterations and the hand-over to the output register.
// ----------------------------------------------------------------------------
module eucl_ctrl
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    input  eucl_pkg::eucl_status_t status,
    output eucl_pkg::eucl_cmd_t    cmd
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_SQUARE = 3'd1;
    localparam logic [2:0] ST_ACCUM  = 3'd2;
    localparam logic [2:0] ST_ROOT   = 3'd3;
    localparam logic [2:0] ST_DONE   = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_comb
    begin
        state_next     = state_reg;
        cmd            = '0;
        case (state_reg)
            ST_IDLE:
            begin
                cmd.idle    = 1'b1;
                cmd.capture = in_valid;
                if (in_valid)
                begin
                    state_next = ST_SQUARE;
                end
            end
            ST_SQUARE:
            begin
                cmd.square = 1'b1;
                state_next = ST_ACCUM;
            end
            ST_ACCUM:
            begin
                cmd.accumulate = 1'b1;
                state_next     = status.last_pending ? ST_ROOT : ST_IDLE;
            end
            ST_ROOT:
            begin
                cmd.root_step = 1'b1;
                if (status.root_done)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                // Wait here only while the previous result is still held.
                if (!status.out_blocked)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// File: sv/eucl_datapath.sv
// ----------------------------------------------------------------------------
// eucl_datapath
// Difference, square, saturating 48-bit accumulator, bitwise square root
// unit (one result bit per cycle) and the output register.
// ----------------------------------------------------------------------------
module eucl_datapath
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  eucl_pkg::eucl_cmd_t                   cmd,
    output eucl_pkg::eucl_status_t                status,
    input  logic signed [eucl_pkg::ELEM_W-1:0]    a_value,
    input  logic signed [eucl_pkg::ELEM_W-1:0]    b_value,
    input  logic                                  last,
    input  logic                                  out_stall,
    output logic                                  out_valid,
    output logic        [eucl_pkg::DIST_W-1:0]    distance,
    output logic                                  saturated
);

    logic signed [eucl_pkg::DIFF_W-1:0] diff_reg;
    logic                               last_reg;
    logic        [eucl_pkg::SQ_W-1:0]   sq_reg;
    logic        [eucl_pkg::SUM_W-1:0]  sum_reg;
    logic        [eucl_pkg::SUM_W-1:0]  sum_next;
    logic                               ovf_reg;
    logic                               ovf_next;
    logic        [eucl_pkg::SUM_W-1:0]  rem_reg;
    logic        [eucl_pkg::SUM_W-1:0]  root_reg;
    logic        [eucl_pkg::SUM_W-1:0]  bit_reg;
    logic                               sat_hold_reg;
    logic                               out_valid_reg;
    logic                               out_valid_next;
    logic        [eucl_pkg::DIST_W-1:0] distance_reg;
    logic                               saturated_reg;

    logic signed [eucl_pkg::DIFF_W-1:0] diff_in;
    logic        [eucl_pkg::DIFF_W-1:0] mag_wide;
    logic        [eucl_pkg::MAG_W-1:0]  mag;
    logic        [eucl_pkg::SUM_W:0]    sum_ext;
    logic                               carry;
    logic        [eucl_pkg::SUM_W-1:0]  sum_sat;
    logic        [eucl_pkg::SUM_W:0]    trial;
    logic                               fits;

    assign diff_in  = eucl_pkg::DIFF_W'(a_value) - eucl_pkg::DIFF_W'(b_value);
    assign mag_wide = diff_reg[eucl_pkg::DIFF_W-1] ? eucl_pkg::DIFF_W'(-diff_reg)
                                                   : eucl_pkg::DIFF_W'(diff_reg);
    assign mag      = mag_wide[eucl_pkg::MAG_W-1:0];

    // A carry out of the 48-bit sum means the sum would pass its range.
    assign sum_ext  = {1'b0, sum_reg} + {{(eucl_pkg::SUM_W + 1 - eucl_pkg::SQ_W){1'b0}}, sq_reg};
    assign carry    = sum_ext[eucl_pkg::SUM_W];
    assign sum_sat  = carry ? {eucl_pkg::SUM_W{1'b1}} : sum_ext[eucl_pkg::SUM_W-1:0];

    assign trial    = {1'b0, root_reg} + {1'b0, bit_reg};
    assign fits     = ({1'b0, rem_reg} >= trial);

    always_comb
    begin
        sum_next = sum_reg;
        ovf_next = ovf_reg;
        if (cmd.accumulate)
        begin
            if (last_reg)
            begin
                sum_next = '0;
                ovf_next = 1'b0;
            end
            else
            begin
                sum_next = sum_sat;
                ovf_next = ovf_reg | carry;
            end
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg       <= '0;
            ovf_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            sum_reg       <= sum_next;
            ovf_reg       <= ovf_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            diff_reg <= diff_in;
            last_reg <= last;
        end
        if (cmd.square)
        begin
            sq_reg <= mag * mag;
        end
        if (cmd.accumulate && last_reg)
        begin
            rem_reg      <= sum_sat;
            root_reg     <= '0;
            bit_reg      <= eucl_pkg::ROOT_BIT_INIT;
            sat_hold_reg <= ovf_reg | carry;
        end
        if (cmd.root_step)
        begin
            if (fits)
            begin
                rem_reg  <= rem_reg - trial[eucl_pkg::SUM_W-1:0];
                root_reg <= (root_reg >> 1) + bit_reg;
            end
            else
            begin
                root_reg <= root_reg >> 1;
            end
            bit_reg <= bit_reg >> 2;
        end
        if (cmd.out_load)
        begin
            distance_reg  <= root_reg[eucl_pkg::DIST_W-1:0];
            saturated_reg <= sat_hold_reg;
        end
    end

    assign status.last_pending = last_reg;
    assign status.root_done    = bit_reg[0];
    assign status.out_blocked  = out_valid_reg & out_stall;

    assign out_valid = out_valid_reg;
    assign distance  = distance_reg;
    assign saturated = saturated_reg;

endmodule

// File: sv/euclidean_distance_engine.sv
// ----------------------------------------------------------------------------
// euclidean_distance_engine
// Euclidean (L2) distance between two streamed fixed-point vectors.
// ----------------------------------------------------------------------------
// Usage: each input item carries one element pair (a_value, b_value, both
// signed 16-bit in a shared scale) and a last marker. The block squares the
// difference and adds it to a saturating 48-bit running sum. On the item
// marked last it returns one result item: distance, the floor of the square
// root of the sum in the element scale, and saturated, set when the sum hit
// its 48-bit ceiling for that vector. The sum then clears for the next vector.
// An item not marked last passes capture, square and accumulate before the
// next item is taken. An item marked last also passes the square root steps
// and the hand-over to the output register before the next item is taken;
// the square root unit resolves one result bit per cycle, 24 bits in all,
// and the hand-over waits while an earlier result is still stalled.
// The result is held in an output register, so the next vector streams in
// while it waits; only a further result blocks when the receiver stalls.
// Reset (rst_n low, asynchronous) clears the sum, the overflow flag, the
// controller and out_valid.
// ----------------------------------------------------------------------------
module euclidean_distance_engine
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic signed [eucl_pkg::ELEM_W-1:0]    a_value,
    input  logic signed [eucl_pkg::ELEM_W-1:0]    b_value,
    input  logic                                  last,
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic        [eucl_pkg::DIST_W-1:0]    distance,
    output logic                                  saturated
);

    eucl_pkg::eucl_cmd_t    cmd;
    eucl_pkg::eucl_status_t status;

    // The controller sequences every item; the datapath only acts on commands.
    eucl_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .status   (status),
        .cmd      (cmd)
    );

    eucl_datapath u_datapath
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .a_value   (a_value),
        .b_value   (b_value),
        .last      (last),
        .out_stall (out_stall),
        .out_valid (out_valid),
        .distance  (distance),
        .saturated (saturated)
    );

    // Items are taken only while the controller is idle.
    assign in_stall = ~cmd.idle;

    // An accepted item keeps the block busy for at least the following cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("item accepted on back-to-back cycles");

    // A saturated sum always gives the largest distance.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && saturated |-> distance == {eucl_pkg::DIST_W{1'b1}})
        else $error("saturated result without full-scale distance");

    // A new result is loaded only when no earlier result is still waiting.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> !(out_valid && out_stall))
        else $error("result overwritten while stalled");

endmodule
